@@ src/bth_pkg.sv @@
// bth_pkg: widths, register codes and pipeline bundles for the beam target hit test.
// Used by every module under src; depends on nothing.
package bth_pkg;

    // Port and field widths
    localparam int COORD_W   = 32;
    localparam int QUAT_W    = 16;
    localparam int RAD_W     = 31;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Rotation datapath widths
    localparam int PROD_W    = 2 * QUAT_W;            // quaternion part products
    localparam int MAT_W     = PROD_W + 2;            // matrix entries, Q.28
    localparam int HALF_W    = 16;                    // coordinate split point
    localparam int PH_W      = MAT_W + HALF_W;        // matrix x high half
    localparam int PL_W      = MAT_W + HALF_W + 1;    // matrix x low half (unsigned)
    localparam int HS_W      = PH_W + 2;              // sum of three high products
    localparam int LS_W      = PL_W + 2;              // sum of three low products
    localparam int ACC_W     = HS_W + HALF_W + 1;     // recombined row sum
    localparam int ROT_SHIFT = 28;
    localparam int ROT_W     = 40;                    // rotated point
    localparam int WORLD_W   = ROT_W + 1;             // rotated point plus position

    // Test datapath widths
    localparam int DIFF_W    = 32;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int DOT_W     = SQ_W + 2;
    localparam int WIDE_W    = 2 * SQ_W;
    localparam int PART_W    = SQ_W / 2;

    localparam logic signed [DIFF_W-1:0] DIFF_MAX = 32'sh7FFF_FFFF;

    // Start to done, in cycles
    localparam int ROT_STAGES = 5;
    localparam int GEO_STAGES = 4;
    localparam int DEC_STAGES = 5;
    localparam int LATENCY    = ROT_STAGES + GEO_STAGES + DEC_STAGES;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIT_RADIUS = 3'd0,
        REG_START_X    = 3'd1,
        REG_START_Y    = 3'd2,
        REG_START_Z    = 3'd3,
        REG_AIM_X      = 3'd4,
        REG_AIM_Y      = 3'd5,
        REG_AIM_Z      = 3'd6
    } cfg_reg_t;

    // Rotation stage to vector stage
    typedef struct packed {
        logic                      valid;
        logic [2:0][ROT_W-1:0]     rs;
        logic [2:0][ROT_W-1:0]     ra;
        logic [2:0][COORD_W-1:0]   pos;
        logic [2:0][COORD_W-1:0]   tgt;
    } rot_t;

    // Vector stage to decision stage
    typedef struct packed {
        logic                      valid;
        logic [SQ_W-1:0]           dd;
        logic [DOT_W-1:0]          dot;
        logic [2:0][SQ_W-1:0]      cr;
    } geo_t;

endpackage

@@ src/bth_rotate.sv @@
// bth_rotate: builds the rotation matrix from the quaternion and rotates both
// model beam points, five register stages. Depends on bth_pkg.
module bth_rotate
    import bth_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [2:0][COORD_W-1:0]       pos_in,
    input  logic [2:0][COORD_W-1:0]       tgt_in,
    input  logic signed [QUAT_W-1:0]      qx,
    input  logic signed [QUAT_W-1:0]      qy,
    input  logic signed [QUAT_W-1:0]      qz,
    input  logic signed [QUAT_W-1:0]      qw,
    input  logic [2:0][COORD_W-1:0]       start_model,
    input  logic [2:0][COORD_W-1:0]       aim_model,
    output rot_t                          rot
);

    // Recombine high and low partial sums, round half up to Q24.16
    function automatic logic signed [ROT_W-1:0] round_row(
        input logic signed [HS_W-1:0] hs,
        input logic signed [LS_W-1:0] ls
    );
        logic signed [ACC_W-1:0] acc;
        acc = (ACC_W'(hs) <<< HALF_W) + ACC_W'(ls) + (ACC_W'(1) <<< (ROT_SHIFT - 1));
        round_row = ROT_W'(acc >>> ROT_SHIFT);
    endfunction

    logic [ROT_STAGES-1:0]          vld_reg;
    logic [2:0][COORD_W-1:0]        pos_reg [ROT_STAGES];
    logic [2:0][COORD_W-1:0]        tgt_reg [ROT_STAGES];

    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PROD_W-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [MAT_W-1:0]  m_reg [9];
    logic signed [PH_W-1:0]   ph_reg [2][3][3];
    logic signed [PL_W-1:0]   pl_reg [2][3][3];
    logic signed [HS_W-1:0]   hs_reg [2][3];
    logic signed [LS_W-1:0]   ls_reg [2][3];
    logic signed [ROT_W-1:0]  rot_reg [2][3];
    logic [2:0][COORD_W-1:0]  vm [2];

    assign vm[0] = start_model;
    assign vm[1] = aim_model;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROT_STAGES-2:0], in_valid};
        end
    end

    // Position and target ride along
    always_ff @(posedge clk)
    begin
        pos_reg[0] <= pos_in;
        tgt_reg[0] <= tgt_in;
        for (int s = 1; s < ROT_STAGES; s++)
        begin
            pos_reg[s] <= pos_reg[s-1];
            tgt_reg[s] <= tgt_reg[s-1];
        end
    end

    // Stage 1: quaternion part products
    always_ff @(posedge clk)
    begin
        xx_reg <= PROD_W'(qx) * PROD_W'(qx);
        yy_reg <= PROD_W'(qy) * PROD_W'(qy);
        zz_reg <= PROD_W'(qz) * PROD_W'(qz);
        ww_reg <= PROD_W'(qw) * PROD_W'(qw);
        xy_reg <= PROD_W'(qx) * PROD_W'(qy);
        wz_reg <= PROD_W'(qw) * PROD_W'(qz);
        xz_reg <= PROD_W'(qx) * PROD_W'(qz);
        wy_reg <= PROD_W'(qw) * PROD_W'(qy);
        yz_reg <= PROD_W'(qy) * PROD_W'(qz);
        wx_reg <= PROD_W'(qw) * PROD_W'(qx);
    end

    // Stage 2: matrix of q v q*, Q.28
    always_ff @(posedge clk)
    begin
        m_reg[0] <= MAT_W'(ww_reg) + MAT_W'(xx_reg) - MAT_W'(yy_reg) - MAT_W'(zz_reg);
        m_reg[1] <= (MAT_W'(xy_reg) - MAT_W'(wz_reg)) <<< 1;
        m_reg[2] <= (MAT_W'(xz_reg) + MAT_W'(wy_reg)) <<< 1;
        m_reg[3] <= (MAT_W'(xy_reg) + MAT_W'(wz_reg)) <<< 1;
        m_reg[4] <= MAT_W'(ww_reg) - MAT_W'(xx_reg) + MAT_W'(yy_reg) - MAT_W'(zz_reg);
        m_reg[5] <= (MAT_W'(yz_reg) - MAT_W'(wx_reg)) <<< 1;
        m_reg[6] <= (MAT_W'(xz_reg) - MAT_W'(wy_reg)) <<< 1;
        m_reg[7] <= (MAT_W'(yz_reg) + MAT_W'(wx_reg)) <<< 1;
        m_reg[8] <= MAT_W'(ww_reg) - MAT_W'(xx_reg) - MAT_W'(yy_reg) + MAT_W'(zz_reg);
    end

    // Stage 3: matrix entries times high and low coordinate halves
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    ph_reg[k][i][j] <= PH_W'(m_reg[3*i+j])
                        * PH_W'($signed(vm[k][j][COORD_W-1:HALF_W]));
                    pl_reg[k][i][j] <= PL_W'(m_reg[3*i+j])
                        * PL_W'($signed({1'b0, vm[k][j][HALF_W-1:0]}));
                end
            end
        end
    end

    // Stage 4: row sums
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hs_reg[k][i] <= HS_W'(ph_reg[k][i][0]) + HS_W'(ph_reg[k][i][1])
                    + HS_W'(ph_reg[k][i][2]);
                ls_reg[k][i] <= LS_W'(pl_reg[k][i][0]) + LS_W'(pl_reg[k][i][1])
                    + LS_W'(pl_reg[k][i][2]);
            end
        end
    end

    // Stage 5: recombine and round
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rot_reg[k][i] <= round_row(hs_reg[k][i], ls_reg[k][i]);
            end
        end
    end

    always_comb
    begin
        rot.valid = vld_reg[ROT_STAGES-1];
        rot.pos   = pos_reg[ROT_STAGES-1];
        rot.tgt   = tgt_reg[ROT_STAGES-1];
        for (int i = 0; i < 3; i++)
        begin
            rot.rs[i] = rot_reg[0][i];
            rot.ra[i] = rot_reg[1][i];
        end
    end

endmodule

@@ src/bth_vector.sv @@
// bth_vector: beam start and direction in world frame, saturated differences,
// squared length, dot product and cross product, four stages. Depends on bth_pkg.
module bth_vector
    import bth_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  rot_t  rot,
    output geo_t  geo
);

    // Saturate a difference to +-(2^31 - 1)
    function automatic logic signed [DIFF_W-1:0] clamp_diff(
        input logic signed [WORLD_W:0] v
    );
        logic signed [WORLD_W:0] lim;
        lim = (WORLD_W+1)'(DIFF_MAX);
        if (v > lim)
            clamp_diff = DIFF_MAX;
        else if (v < -lim)
            clamp_diff = -DIFF_MAX;
        else
            clamp_diff = DIFF_W'(v);
    endfunction

    logic [GEO_STAGES-1:0]     vld_reg;
    logic signed [WORLD_W-1:0] s_reg [3];
    logic signed [WORLD_W-1:0] p_reg [3];
    logic [2:0][COORD_W-1:0]   t_reg;
    logic signed [DIFF_W-1:0]  d_reg [3];
    logic signed [DIFF_W-1:0]  w_reg [3];
    logic signed [SQ_W-1:0]    dd_p_reg [3];
    logic signed [SQ_W-1:0]    wd_p_reg [3];
    logic signed [SQ_W-1:0]    ca_reg [3];
    logic signed [SQ_W-1:0]    cb_reg [3];
    logic [SQ_W-1:0]           dd_reg;
    logic signed [DOT_W-1:0]   dot_reg;
    logic [2:0][SQ_W-1:0]      cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[GEO_STAGES-2:0], rot.valid};
        end
    end

    // Stage 1: world beam points
    always_ff @(posedge clk)
    begin
        t_reg <= rot.tgt;
        for (int i = 0; i < 3; i++)
        begin
            s_reg[i] <= WORLD_W'($signed(rot.rs[i])) + WORLD_W'($signed(rot.pos[i]));
            p_reg[i] <= WORLD_W'($signed(rot.ra[i])) + WORLD_W'($signed(rot.pos[i]));
        end
    end

    // Stage 2: direction d and target offset w, saturated
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i] <= clamp_diff((WORLD_W+1)'(p_reg[i]) - (WORLD_W+1)'(s_reg[i]));
            w_reg[i] <= clamp_diff((WORLD_W+1)'($signed(t_reg[i]))
                - (WORLD_W+1)'(s_reg[i]));
        end
    end

    // Stage 3: products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd_p_reg[i] <= SQ_W'(d_reg[i]) * SQ_W'(d_reg[i]);
            wd_p_reg[i] <= SQ_W'(w_reg[i]) * SQ_W'(d_reg[i]);
        end
        ca_reg[0] <= SQ_W'(w_reg[1]) * SQ_W'(d_reg[2]);
        cb_reg[0] <= SQ_W'(w_reg[2]) * SQ_W'(d_reg[1]);
        ca_reg[1] <= SQ_W'(w_reg[2]) * SQ_W'(d_reg[0]);
        cb_reg[1] <= SQ_W'(w_reg[0]) * SQ_W'(d_reg[2]);
        ca_reg[2] <= SQ_W'(w_reg[0]) * SQ_W'(d_reg[1]);
        cb_reg[2] <= SQ_W'(w_reg[1]) * SQ_W'(d_reg[0]);
    end

    // Stage 4: sums; cross terms stay below 2^63 in magnitude
    always_ff @(posedge clk)
    begin
        dd_reg  <= SQ_W'(dd_p_reg[0]) + SQ_W'(dd_p_reg[1]) + SQ_W'(dd_p_reg[2]);
        dot_reg <= DOT_W'(wd_p_reg[0]) + DOT_W'(wd_p_reg[1]) + DOT_W'(wd_p_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            cr_reg[i] <= SQ_W'(ca_reg[i] - cb_reg[i]);
        end
    end

    assign geo.valid = vld_reg[GEO_STAGES-1];
    assign geo.dd    = dd_reg;
    assign geo.dot   = dot_reg;
    assign geo.cr    = cr_reg;

endmodule

@@ src/bth_decide.sv @@
// bth_decide: exact 128-bit behind and hit tests from 32x32 partial products,
// five stages, registered flags and strobe. Depends on bth_pkg.
module bth_decide
    import bth_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  geo_t              geo,
    input  logic [RAD_W-1:0]  hit_radius,
    output logic              done,
    output logic              hit,
    output logic              behind
);

    // Step e = round(0.01 * 2^FRAC_BITS) and its square
    localparam longint STEP_Q = ((64'sd1 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam int     E2_W   = 2 * FRAC_BITS - 10;
    localparam int     EP_W   = E2_W + PART_W;
    localparam logic [E2_W-1:0] E2 = E2_W'(STEP_Q * STEP_Q);

    logic [DEC_STAGES-2:0] vld_reg;

    // Stage 1
    logic              nz1_reg, pos1_reg, small1_reg;
    logic [SQ_W-1:0]   a1_reg, dd1_reg, r2_1_reg;
    logic [SQ_W-1:0]   mc1_reg [3];
    // Stage 2
    logic              nz2_reg, pos2_reg, small2_reg;
    logic [SQ_W-1:0]   a_ll_reg, a_hl_reg, a_hh_reg;
    logic [SQ_W-1:0]   c_ll_reg [3];
    logic [SQ_W-1:0]   c_hl_reg [3];
    logic [SQ_W-1:0]   c_hh_reg [3];
    logic [EP_W-1:0]   e_l_reg, e_h_reg;
    logic [SQ_W-1:0]   r_ll_reg, r_lh_reg, r_hl_reg, r_hh_reg;
    // Stage 3
    logic              nz3_reg, pos3_reg, small3_reg;
    logic [WIDE_W-1:0] a2_reg, ed_reg, rr3_reg;
    logic [WIDE_W-1:0] c2_reg [3];
    // Stage 4
    logic              nz4_reg, beh4_reg;
    logic [WIDE_W-1:0] lhs_reg, rr4_reg;
    // Stage 5
    logic              done_reg, hit_reg, behind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DEC_STAGES-3:0], geo.valid};
        end
    end

    // Stage 1: signs, magnitudes, radius squared
    always_ff @(posedge clk)
    begin
        nz1_reg    <= (geo.dd != '0);
        pos1_reg   <= !geo.dot[DOT_W-1] && (geo.dot != '0);
        small1_reg <= (geo.dot[DOT_W-1:SQ_W-1] == '0);
        a1_reg     <= {geo.dot[SQ_W-2:0], 1'b0};
        dd1_reg    <= geo.dd;
        r2_1_reg   <= SQ_W'(hit_radius) * SQ_W'(hit_radius);
        for (int k = 0; k < 3; k++)
        begin
            mc1_reg[k] <= geo.cr[k][SQ_W-1] ? SQ_W'(-$signed(geo.cr[k])) : geo.cr[k];
        end
    end

    // Stage 2: 32x32 partial products
    always_ff @(posedge clk)
    begin
        nz2_reg    <= nz1_reg;
        pos2_reg   <= pos1_reg;
        small2_reg <= small1_reg;
        a_ll_reg <= SQ_W'(a1_reg[PART_W-1:0]) * SQ_W'(a1_reg[PART_W-1:0]);
        a_hl_reg <= SQ_W'(a1_reg[SQ_W-1:PART_W]) * SQ_W'(a1_reg[PART_W-1:0]);
        a_hh_reg <= SQ_W'(a1_reg[SQ_W-1:PART_W]) * SQ_W'(a1_reg[SQ_W-1:PART_W]);
        for (int k = 0; k < 3; k++)
        begin
            c_ll_reg[k] <= SQ_W'(mc1_reg[k][PART_W-1:0]) * SQ_W'(mc1_reg[k][PART_W-1:0]);
            c_hl_reg[k] <= SQ_W'(mc1_reg[k][SQ_W-1:PART_W])
                * SQ_W'(mc1_reg[k][PART_W-1:0]);
            c_hh_reg[k] <= SQ_W'(mc1_reg[k][SQ_W-1:PART_W])
                * SQ_W'(mc1_reg[k][SQ_W-1:PART_W]);
        end
        e_l_reg  <= EP_W'(E2) * EP_W'(dd1_reg[PART_W-1:0]);
        e_h_reg  <= EP_W'(E2) * EP_W'(dd1_reg[SQ_W-1:PART_W]);
        r_ll_reg <= SQ_W'(r2_1_reg[PART_W-1:0]) * SQ_W'(dd1_reg[PART_W-1:0]);
        r_lh_reg <= SQ_W'(r2_1_reg[PART_W-1:0]) * SQ_W'(dd1_reg[SQ_W-1:PART_W]);
        r_hl_reg <= SQ_W'(r2_1_reg[SQ_W-1:PART_W]) * SQ_W'(dd1_reg[PART_W-1:0]);
        r_hh_reg <= SQ_W'(r2_1_reg[SQ_W-1:PART_W]) * SQ_W'(dd1_reg[SQ_W-1:PART_W]);
    end

    // Stage 3: assemble full products
    always_ff @(posedge clk)
    begin
        nz3_reg    <= nz2_reg;
        pos3_reg   <= pos2_reg;
        small3_reg <= small2_reg;
        a2_reg  <= (WIDE_W'(a_hh_reg) << SQ_W) + (WIDE_W'(a_hl_reg) << (PART_W + 1))
            + WIDE_W'(a_ll_reg);
        for (int k = 0; k < 3; k++)
        begin
            c2_reg[k] <= (WIDE_W'(c_hh_reg[k]) << SQ_W)
                + (WIDE_W'(c_hl_reg[k]) << (PART_W + 1)) + WIDE_W'(c_ll_reg[k]);
        end
        ed_reg  <= (WIDE_W'(e_h_reg) << PART_W) + WIDE_W'(e_l_reg);
        rr3_reg <= (WIDE_W'(r_hh_reg) << SQ_W) + (WIDE_W'(r_lh_reg) << PART_W)
            + (WIDE_W'(r_hl_reg) << PART_W) + WIDE_W'(r_ll_reg);
    end

    // Stage 4: behind test, squared cross length
    always_ff @(posedge clk)
    begin
        nz4_reg  <= nz3_reg;
        beh4_reg <= nz3_reg && (!pos3_reg || (small3_reg && (a2_reg < ed_reg)));
        lhs_reg  <= c2_reg[0] + c2_reg[1] + c2_reg[2];
        rr4_reg  <= rr3_reg;
    end

    // Stage 5: hit test and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            behind_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= vld_reg[DEC_STAGES-2];
            hit_reg    <= vld_reg[DEC_STAGES-2] && nz4_reg && !beh4_reg
                && (lhs_reg <= rr4_reg);
            behind_reg <= vld_reg[DEC_STAGES-2] && beh4_reg;
        end
    end

    assign done   = done_reg;
    assign hit    = hit_reg;
    assign behind = behind_reg;

endmodule

@@ src/beam_target_hit_test.sv @@
// beam_target_hit_test: top level; configuration registers and the three
// pipeline sections. Depends on bth_pkg, bth_rotate, bth_vector, bth_decide.
//
//  channel   handshake             payload
//  --------  --------------------  -----------------------------------------
//  command   start, busy           source_x/y/z, quat_x/y/z/w, target_x/y/z
//  result    done (one cycle)      hit, behind
//  config    cfg_wr_en             cfg_index, cfg_data
//
// One transaction per cycle; done follows start through the 5 rotation,
// 4 vector and 5 decision stages of the multiplier pipeline.
// busy stays low: the pipeline never stalls and the receiver cannot hold off.
// rst_n clears valid bits, flags and configuration to their reset values.
module beam_target_hit_test
    import bth_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [COORD_W-1:0]  source_x,
    input  logic signed [COORD_W-1:0]  source_y,
    input  logic signed [COORD_W-1:0]  source_z,
    input  logic signed [QUAT_W-1:0]   quat_x,
    input  logic signed [QUAT_W-1:0]   quat_y,
    input  logic signed [QUAT_W-1:0]   quat_z,
    input  logic signed [QUAT_W-1:0]   quat_w,
    input  logic signed [COORD_W-1:0]  target_x,
    input  logic signed [COORD_W-1:0]  target_y,
    input  logic signed [COORD_W-1:0]  target_z,
    output logic                       done,
    output logic                       hit,
    output logic                       behind,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    logic [RAD_W-1:0]          hit_radius_reg;
    logic [2:0][COORD_W-1:0]   start_model_reg;
    logic [2:0][COORD_W-1:0]   aim_model_reg;
    rot_t                      rot;
    geo_t                      geo;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_radius_reg  <= 31'h0001_0000;
            start_model_reg <= '0;
            aim_model_reg   <= {32'h0001_0000, 32'h0000_0000, 32'h0000_0000};
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HIT_RADIUS: hit_radius_reg     <= cfg_data[RAD_W-1:0];
                REG_START_X:    start_model_reg[0] <= cfg_data;
                REG_START_Y:    start_model_reg[1] <= cfg_data;
                REG_START_Z:    start_model_reg[2] <= cfg_data;
                REG_AIM_X:      aim_model_reg[0]   <= cfg_data;
                REG_AIM_Y:      aim_model_reg[1]   <= cfg_data;
                REG_AIM_Z:      aim_model_reg[2]   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Always ready for the next command
    assign busy = 1'b0;

    bth_rotate u_rotate (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .pos_in      ({source_z, source_y, source_x}),
        .tgt_in      ({target_z, target_y, target_x}),
        .qx          (quat_x),
        .qy          (quat_y),
        .qz          (quat_z),
        .qw          (quat_w),
        .start_model (start_model_reg),
        .aim_model   (aim_model_reg),
        .rot         (rot)
    );

    bth_vector u_vector (
        .clk   (clk),
        .rst_n (rst_n),
        .rot   (rot),
        .geo   (geo)
    );

    bth_decide #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .geo        (geo),
        .hit_radius (hit_radius_reg),
        .done       (done),
        .hit        (hit),
        .behind     (behind)
    );

endmodule

@@ src/bth_checker.sv @@
// bth_checker: port-level assertions for beam_target_hit_test, bound to it.
// Depends on bth_pkg.
module bth_checker
    import bth_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic hit,
    input logic behind
);

    // Every accepted transaction gives exactly one result after the latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction produced no result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

    // A target behind the beam is never a hit
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && behind))
        else $error("hit and behind both set");

    // Flags are quiet between results
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!hit && !behind))
        else $error("flags set without done");

endmodule

bind beam_target_hit_test bth_checker u_checker (.*);
